### src/ffdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffdc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 20;

    localparam int DEF_BUFFER_DEPTH = 65536;
    localparam int DEF_SMOOTH_SHIFT = 10;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_TIME  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WET_MIX     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_EFFECT_MODE = 3'd4;

    localparam logic MODE_DELAY  = 1'b0;
    localparam logic MODE_CHORUS = 1'b1;

    // serial divider sizes
    localparam int DIV_W = 54;
    localparam int DVS_W = 25;

    // target delay is floor((K + 500000) / 10^6), done as a reciprocal multiply
    localparam logic [53:0]      RCP_HALF   = 54'd500000;
    localparam logic [48:0]      RCP_MAGIC  = 49'd295147905179353; // ceil(2^62 / 15625)
    localparam logic [19:0]      GAIN_MAGIC = 20'd838861; // ceil(2^22 / 5)
    localparam logic [25:0]      CLIP_K     = 26'd1769472; // 27 in Q16

    typedef struct packed {
        logic clear_step;
        logic load;
        logic tgt_mul;
        logic div_tgt;
        logic smooth;
        logic addr;
        logic rd0;
        logic rd1;
        logic take_y1;
        logic interp;
        logic dly;
        logic div_clip;
        logic clip_mul;
        logic finish;
    } ffdc_cmd_t;

    typedef struct packed {
        logic wi_last;
        logic div_busy;
        logic out_full;
    } ffdc_sts_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sh7fff;
        end else if (v < -24'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

### src/ffdc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ffdc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [ffdc_pkg::DIV_W-1:0] dividend,
    input  wire logic [ffdc_pkg::DVS_W-1:0] divisor,
    output logic                            busy,
    output logic [ffdc_pkg::DIV_W-1:0]      quotient
);
    import ffdc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restoring step: one quotient bit per cycle
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### src/ffdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ffdc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire ffdc_pkg::ffdc_sts_t sts,
    output ffdc_pkg::ffdc_cmd_t      cmd
);
    import ffdc_pkg::*;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_TGT    = 4'd2;
    localparam logic [3:0] ST_DIVT   = 4'd3;
    localparam logic [3:0] ST_DIVTW  = 4'd4;
    localparam logic [3:0] ST_SMOOTH = 4'd5;
    localparam logic [3:0] ST_ADDR   = 4'd6;
    localparam logic [3:0] ST_RD0    = 4'd7;
    localparam logic [3:0] ST_RD1    = 4'd8;
    localparam logic [3:0] ST_Y1     = 4'd9;
    localparam logic [3:0] ST_INTERP = 4'd10;
    localparam logic [3:0] ST_DLY    = 4'd11;
    localparam logic [3:0] ST_DIVC   = 4'd12;
    localparam logic [3:0] ST_DIVCW  = 4'd13;
    localparam logic [3:0] ST_CMUL   = 4'd14;
    localparam logic [3:0] ST_FIN    = 4'd15;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.wi_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TGT;
                end
            end
            ST_TGT: begin
                cmd.tgt_mul = 1'b1;
                state_next  = ST_DIVT;
            end
            ST_DIVT: begin
                cmd.div_tgt = 1'b1;
                state_next  = ST_DIVTW;
            end
            ST_DIVTW: begin
                if (!sts.div_busy) begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                cmd.smooth = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0: begin
                cmd.rd0    = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd1    = 1'b1;
                state_next = ST_Y1;
            end
            ST_Y1: begin
                cmd.take_y1 = 1'b1;
                state_next  = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.interp = 1'b1;
                state_next = ST_DLY;
            end
            ST_DLY: begin
                cmd.dly    = 1'b1;
                state_next = ST_DIVC;
            end
            ST_DIVC: begin
                cmd.div_clip = 1'b1;
                state_next   = ST_DIVCW;
            end
            ST_DIVCW: begin
                if (!sts.div_busy) begin
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL: begin
                cmd.clip_mul = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!sts.out_full) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### src/ffdc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ffdc_dp #(
    parameter int BUFFER_DEPTH = ffdc_pkg::DEF_BUFFER_DEPTH,
    parameter int SMOOTH_SHIFT = ffdc_pkg::DEF_SMOOTH_SHIFT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [2*ffdc_pkg::SAMPLE_BITS-1:0] s_tdata,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [ffdc_pkg::SAMPLE_BITS-1:0]     m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ffdc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ffdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire ffdc_pkg::ffdc_cmd_t             cmd,
    output ffdc_pkg::ffdc_sts_t                  sts
);
    import ffdc_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int SDW = AW + 16;
    localparam int RPW = SDW + 1;
    localparam logic [AW-1:0]    IDX_LAST = AW'(BUFFER_DEPTH - 1);
    localparam logic [RPW-1:0]   TOTAL    = RPW'(BUFFER_DEPTH) << 16;
    localparam logic [SDW-1:0]   LIMIT    = SDW'(BUFFER_DEPTH - 2) << 16;
    localparam logic [35:0]      LIMIT_Q  = 36'(BUFFER_DEPTH - 2) << 16;

    // configuration
    logic [17:0] sample_rate_reg;
    logic [19:0] delay_time_reg;
    logic [15:0] feedback_reg;
    logic [15:0] wet_mix_reg;
    logic        mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= 18'd48000;
            delay_time_reg  <= '0;
            feedback_reg    <= '0;
            wet_mix_reg     <= 16'd32768;
            mode_reg        <= MODE_DELAY;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SAMPLE_RATE: sample_rate_reg <= cfg_wdata[17:0];
                REG_DELAY_TIME:  delay_time_reg  <= cfg_wdata;
                REG_FEEDBACK:    feedback_reg    <= cfg_wdata[15:0];
                REG_WET_MIX:     wet_mix_reg     <= cfg_wdata[15:0];
                REG_EFFECT_MODE: mode_reg        <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // delay store
    logic [SAMPLE_BITS-1:0] store [BUFFER_DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    // item state
    logic [AW-1:0]  wi_reg;
    logic [SDW-1:0] sd_reg;
    logic signed [15:0] last_reg;
    logic           m_tvalid_reg;
    logic [15:0]    m_tdata_reg;

    // working registers
    logic signed [15:0] audio_reg, mod_reg;
    logic [37:0]        tprod_reg;
    logic [AW-1:0]      ip_reg, i0_reg;
    logic [15:0]        frac_reg;
    logic [16:0]        gain_reg;
    logic signed [15:0] y0_reg, y1_reg;
    logic signed [33:0] fbprod_reg, iprod_reg;
    logic signed [15:0] delayed_reg;
    logic [17:0]        a_reg;
    logic               neg_reg;
    logic [35:0]        sq_reg;
    logic signed [33:0] m1_reg;
    logic signed [32:0] m2_reg;
    logic [38:0]        magprod_reg;

    // divider
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_busy;
    logic [DIV_W-1:0] div_quo;

    ffdc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // clip operands
    logic [21:0]      t_val;
    logic [25:0]      num_val, den_val;

    assign t_val     = sq_reg[35:14];
    assign num_val   = CLIP_K + 26'(t_val);
    assign den_val   = CLIP_K + 26'(t_val) * 26'd9;

    assign div_start    = cmd.div_clip;
    assign div_dividend = DIV_W'(num_val) << 20;
    assign div_divisor  = den_val[DVS_W-1:0];

    // target delay: scale chorus so both modes divide by 10^6, then multiply
    // (X >> 6) by ceil(2^62 / 15625), one 16-bit slice a cycle, low slice first
    logic [53:0] rcp_x;
    logic [47:0] rcp_y_reg;
    logic [65:0] rcp_acc_reg;
    logic [1:0]  rcp_cnt_reg;
    logic        rcp_busy_reg;
    logic [35:0] tgt_q;

    always_comb begin
        if (mode_reg == MODE_CHORUS) begin
            rcp_x = 54'(tprod_reg) * 54'd2000 + RCP_HALF;
        end else begin
            rcp_x = {tprod_reg[37:0], 16'b0} + RCP_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcp_busy_reg <= 1'b0;
            rcp_cnt_reg  <= '0;
        end else if (cmd.div_tgt) begin
            rcp_busy_reg <= 1'b1;
            rcp_cnt_reg  <= 2'd2;
        end else if (rcp_busy_reg) begin
            rcp_busy_reg <= (rcp_cnt_reg != 2'd0);
            rcp_cnt_reg  <= rcp_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_tgt) begin
            rcp_y_reg   <= rcp_x[53:6];
            rcp_acc_reg <= '0;
        end else if (rcp_busy_reg) begin
            rcp_y_reg   <= rcp_y_reg >> 16;
            rcp_acc_reg <= (rcp_acc_reg >> 16) + 66'(rcp_y_reg[15:0]) * 66'(RCP_MAGIC);
        end
    end

    assign tgt_q = rcp_acc_reg[65:30];

    // smoother
    logic [SDW-1:0] tgt;
    logic [SDW-1:0] sd_step, sd_new;

    always_comb begin
        tgt = (tgt_q > LIMIT_Q) ? LIMIT : tgt_q[SDW-1:0];
        if (tgt >= sd_reg) begin
            sd_step = (tgt - sd_reg) >> SMOOTH_SHIFT;
            sd_new  = sd_reg + sd_step;
        end else begin
            sd_step = (sd_reg - tgt) >> SMOOTH_SHIFT;
            sd_new  = sd_reg - sd_step;
        end
        if (sd_new > LIMIT) begin
            sd_new = LIMIT;
        end
    end

    // read position
    logic [RPW-1:0] rp_raw, rp;
    logic [AW-1:0]  ip;

    always_comb begin
        rp_raw = {1'b0, wi_reg, 16'b0} + TOTAL - {1'b0, sd_reg};
        rp     = (rp_raw >= TOTAL) ? rp_raw - TOTAL : rp_raw;
        ip     = rp[SDW-1:16];
    end

    logic [18:0] gain_x;
    logic [38:0] gain_prod;
    assign gain_x    = 19'(feedback_reg) * 19'd6 + 19'd2;
    assign gain_prod = 39'(gain_x) * 39'(GAIN_MAGIC);

    logic [17:0]        span;
    logic signed [18:0] span_s;
    assign span_s = 19'sd98304 + (19'(mod_reg) <<< 1);
    assign span   = span_s[17:0];

    // interpolation and feedback sum
    logic signed [16:0] diff;
    logic signed [17:0] fb;
    logic signed [34:0] fb_sum;
    logic signed [18:0] s_val;
    assign diff   = 17'(y1_reg) - 17'(y0_reg);
    assign fb_sum = 35'(fbprod_reg) + 35'sd32768;
    assign fb     = fb_sum[33:16];
    assign s_val  = 19'(audio_reg) + 19'(fb);

    logic signed [35:0] int_acc;
    assign int_acc = (36'(y0_reg) <<< 16) + 36'(iprod_reg) + 36'sd32768;

    logic [16:0] dry_w;
    assign dry_w = 17'd65536 - 17'(wet_mix_reg);

    logic [18:0]            mag;
    logic signed [23:0]     clip_v;
    logic signed [SAMPLE_BITS-1:0] clip_s;
    logic signed [34:0]     mix_acc;
    logic signed [SAMPLE_BITS-1:0] mix_s;

    assign mag     = magprod_reg[38:20] + 19'(magprod_reg[19]);
    assign clip_v  = neg_reg ? -24'(mag) : 24'(mag);
    assign clip_s  = sat_sample(clip_v);
    assign mix_acc = 35'(m1_reg) + 35'(m2_reg) + 35'sd32768;
    assign mix_s   = sat_sample(24'($signed(mix_acc[34:16])));

    always_comb begin
        rd_addr   = cmd.rd0 ? i0_reg : ip_reg;
        mem_we    = cmd.clear_step | cmd.finish;
        mem_wdata = cmd.clear_step ? '0 : clip_s;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[wi_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd0 | cmd.rd1) begin
            rdata_reg <= store[rd_addr];
        end
    end

    // state that reset clears
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg       <= '0;
            sd_reg       <= '0;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                wi_reg <= (wi_reg == IDX_LAST) ? '0 : wi_reg + 1'b1;
            end
            if (cmd.smooth) begin
                sd_reg <= sd_new;
            end
            if (cmd.finish) begin
                last_reg     <= delayed_reg;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            audio_reg <= s_tdata[15:0];
            mod_reg   <= s_tdata[31:16];
        end
        if (cmd.tgt_mul) begin
            tprod_reg <= (mode_reg == MODE_CHORUS) ? 38'(sample_rate_reg) * 38'(span)
                                                   : 38'(delay_time_reg) * 38'(sample_rate_reg);
        end
        if (cmd.addr) begin
            ip_reg   <= ip;
            i0_reg   <= (ip == '0) ? IDX_LAST : ip - 1'b1;
            frac_reg <= rp[15:0];
            gain_reg <= (mode_reg == MODE_CHORUS) ? '0 : gain_prod[38:22];
        end
        if (cmd.rd1) begin
            y0_reg <= rdata_reg;
        end
        if (cmd.take_y1) begin
            y1_reg     <= rdata_reg;
            fbprod_reg <= 34'(last_reg) * $signed({1'b0, gain_reg});
        end
        if (cmd.interp) begin
            iprod_reg <= 34'(diff) * $signed({1'b0, frac_reg});
            neg_reg   <= s_val[18];
            a_reg     <= s_val[18] ? 18'(-s_val) : 18'(s_val);
        end
        if (cmd.dly) begin
            delayed_reg <= sat_sample(24'($signed(int_acc[35:16])));
            sq_reg      <= 36'(a_reg) * 36'(a_reg);
        end
        if (cmd.div_clip) begin
            m1_reg <= 34'(audio_reg) * $signed({1'b0, dry_w});
            m2_reg <= 33'(delayed_reg) * $signed({1'b0, wet_mix_reg});
        end
        if (cmd.clip_mul) begin
            magprod_reg <= 39'(a_reg) * 39'(div_quo[20:0]);
        end
        if (cmd.finish) begin
            m_tdata_reg <= mix_s;
        end
    end

    assign sts.wi_last  = (wi_reg == IDX_LAST);
    assign sts.div_busy = div_busy | rcp_busy_reg;
    assign sts.out_full = m_tvalid_reg;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

endmodule
`default_nettype wire

### src/fractional_feedback_delay_chorus.sv
`timescale 1ns / 1ps
`default_nettype none
// Feedback delay / chorus: one audio and one modulation sample in, one mixed
// sample out. After reset the delay store is swept to zero, one entry a cycle,
// before the first request is taken; configuration writes are taken at any
// time. Each request then runs the 54-step serial divider for the soft-clip
// ratio, a three-step reciprocal multiply for the target delay, two store
// reads and one write between its acceptance and the next ready.
// A finished sample waits in the output register while the next request runs;
// that request holds in its last step until the register has been taken.
module fractional_feedback_delay_chorus #(
    parameter int BUFFER_DEPTH = ffdc_pkg::DEF_BUFFER_DEPTH,
    parameter int SMOOTH_SHIFT = ffdc_pkg::DEF_SMOOTH_SHIFT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [2*ffdc_pkg::SAMPLE_BITS-1:0]  s_tdata,  // audio_in, mod_in
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ffdc_pkg::SAMPLE_BITS-1:0]         m_tdata,  // audio_out
    input  wire logic                                cfg_wr_en,
    input  wire logic [ffdc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [ffdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ffdc_pkg::*;

    ffdc_cmd_t cmd;
    ffdc_sts_t sts;

    ffdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffdc_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SMOOTH_SHIFT (SMOOTH_SHIFT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while one is in flight");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !sts.out_full)
        else $error("result written over a pending one");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_tgt || cmd.div_clip) |-> !sts.div_busy)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire
